### src/hclme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hclme_pkg: shared types and constants for the hard-cross lattice engine
// Site codes, status codes, controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package hclme_pkg;

  localparam int SIDE_DEF = 64;
  localparam int MAX_PART_DEF = 1024;

  localparam logic [1:0] SITE_EMPTY = 2'd0;
  localparam logic [1:0] SITE_CENTER = 2'd2;
  localparam logic [1:0] SITE_ARM = 2'd3;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_BLOCKED = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  localparam logic OP_PLACE = 1'b0;
  localparam logic OP_MOVE = 1'b1;

  localparam logic [2:0] CLS_OTHER = 3'd4;

  // site access: row/col offsets relative to a base point
  typedef struct packed {
    logic       load;     // capture input beat
    logic       rd;       // issue a site read
    logic       wr;       // issue a site write
    logic       use_p0;   // base is particle 0
    logic [3:0] dr;       // signed row offset
    logic [3:0] dc;       // signed col offset
    logic [1:0] wdata;
    logic       chk_empty;  // accumulate "not empty" on returned data
    logic       chk_center; // accumulate "is center" on returned data
    logic       chk_self;   // returned data must be a center
    logic [2:0] cls_bit;    // classify bit slot (0 none, 1..5)
    logic       commit_pos; // write position table
    logic       clr_acc;
    logic       pos_rd;     // read position table for load index
  } hclme_cmd_t;

  typedef struct packed {
    logic hit;       // some checked site failed
    logic self_bad;  // stored center not a center
  } hclme_sts_t;

endpackage

### src/hclme_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hclme_in_if / hclme_out_if: valid/ready channels
// Input item and result item channels of the lattice engine.
// ----------------------------------------------------------------------------
interface hclme_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [9:0] particle;
  logic [1:0] direction;
  logic [5:0] place_row;
  logic [5:0] place_col;
  logic       measure;
  modport source (output valid, opcode, particle, direction, place_row, place_col, measure,
                  input ready);
  modport sink (input valid, opcode, particle, direction, place_row, place_col, measure,
                output ready);
endinterface

interface hclme_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [5:0] new_row;
  logic [5:0] new_col;
  logic [2:0] neighbour_class;
  logic       class_valid;
  modport source (output valid, status, new_row, new_col, neighbour_class, class_valid,
                  input ready);
  modport sink (input valid, status, new_row, new_col, neighbour_class, class_valid,
                output ready);
endinterface

### src/hclme_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hclme_datapath: site memory, position table and check accumulators
// One site access per cycle; read data registered, checked in the next cycle.
// ----------------------------------------------------------------------------
module hclme_datapath #(
  parameter int SIDE = 64,
  parameter int MAX_PARTICLES = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  hclme_pkg::hclme_cmd_t  cmd,
  input  logic [9:0]             particle,
  input  logic [1:0]             direction,
  input  logic [5:0]             place_row,
  input  logic [5:0]             place_col,
  input  logic                   opcode,
  input  logic                   clr_run,
  input  logic [$clog2(SIDE*SIDE)-1:0] clr_addr,
  output hclme_pkg::hclme_sts_t  sts,
  output logic [5:0]             pos_row,
  output logic [5:0]             pos_col,
  output logic [2:0]             cls
);
  import hclme_pkg::*;

  localparam int CW = $clog2(SIDE);
  localparam int AW = 2 * CW;
  localparam int PW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

  logic [1:0]    sites [SIDE*SIDE];
  logic [CW-1:0] crow [MAX_PARTICLES];
  logic [CW-1:0] ccol [MAX_PARTICLES];

  logic [CW-1:0] base_r, base_c, p0_r, p0_c;
  logic [PW-1:0] idx;
  logic [1:0]    dir;
  logic [1:0]    rdata;
  logic          chk_e, chk_c, chk_s;
  logic [2:0]    chk_b;
  logic          hit, self_bad;
  logic [4:0]    cbits;

  logic [CW-1:0] fr, fc;
  logic [CW-1:0] ar, ac, off_r, off_c;
  logic [AW-1:0] addr;

  // map local frame (forward, side) offsets into row/col for moves
  always_comb begin
    off_r = CW'(signed'(cmd.dr));
    off_c = CW'(signed'(cmd.dc));
    fr = off_r;
    fc = off_c;
    if (!cmd.use_p0 && opcode == OP_MOVE) begin
      // dr = forward count, dc = side count; dir 0: f=(0,+1) s=(+1,0)
      case (dir)
        2'd0: begin fr = off_c; fc = off_r; end
        2'd1: begin fr = -off_r; fc = off_c; end
        2'd2: begin fr = off_c; fc = -off_r; end
        default: begin fr = off_r; fc = off_c; end
      endcase
    end
    ar = (cmd.use_p0 ? p0_r : base_r) + fr;
    ac = (cmd.use_p0 ? p0_c : base_c) + fc;
    addr = {ar, ac};
  end

  always_ff @(posedge clk) begin
    if (clr_run) begin
      sites[clr_addr[AW-1:0]] <= SITE_EMPTY;
    end else if (cmd.wr) begin
      sites[addr] <= cmd.wdata;
    end
    if (cmd.rd) begin
      rdata <= sites[addr];
    end
    // particle 0 position tracked every cycle
    p0_r <= crow[0];
    p0_c <= ccol[0];
    if (cmd.load) begin
      idx <= PW'(particle);
      dir <= direction;
      base_r <= CW'(place_row);
      base_c <= CW'(place_col);
    end
    if (cmd.pos_rd) begin
      base_r <= crow[idx];
      base_c <= ccol[idx];
    end
    if (cmd.commit_pos) begin
      crow[idx] <= ar;
      ccol[idx] <= ac;
      base_r <= ar;
      base_c <= ac;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_acc) begin
      chk_e <= 1'b0;
      chk_c <= 1'b0;
      chk_s <= 1'b0;
      chk_b <= 3'd0;
      hit <= 1'b0;
      self_bad <= 1'b0;
      cbits <= 5'd0;
    end else begin
      chk_e <= cmd.chk_empty;
      chk_c <= cmd.chk_center;
      chk_s <= cmd.chk_self;
      chk_b <= cmd.cls_bit;
      if (chk_e && rdata != SITE_EMPTY) hit <= 1'b1;
      if (chk_c && rdata == SITE_CENTER) hit <= 1'b1;
      if (chk_s && rdata != SITE_CENTER) self_bad <= 1'b1;
      if (chk_b != 3'd0 && rdata == SITE_CENTER) cbits[chk_b - 3'd1] <= 1'b1;
    end
  end

  always_comb begin
    sts.hit = hit;
    sts.self_bad = self_bad;
    pos_row = 6'(base_r);
    pos_col = 6'(base_c);
    if (cbits[3] || cbits[4]) cls = CLS_OTHER;
    else begin
      case (cbits[2:0])
        3'b000: cls = 3'd0;
        3'b001: cls = 3'd1;
        3'b010: cls = 3'd2;
        3'b100: cls = 3'd3;
        default: cls = CLS_OTHER;
      endcase
    end
  end

endmodule

### src/hclme_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hclme_ctrl: sequencer for place, move and measure
// Steps through the site accesses of one item and drives the result beat.
// ----------------------------------------------------------------------------
module hclme_ctrl #(
  parameter int SIDE = 64,
  parameter int MAX_PARTICLES = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  hclme_in_if.sink               in_ch,
  hclme_out_if.source            out_ch,
  input  hclme_pkg::hclme_sts_t  sts,
  input  logic [5:0]             pos_row,
  input  logic [5:0]             pos_col,
  input  logic [2:0]             cls,
  output hclme_pkg::hclme_cmd_t  cmd,
  output logic                   clr_run,
  output logic [$clog2(SIDE*SIDE)-1:0] clr_addr,
  output logic                   opcode
);
  import hclme_pkg::*;

  localparam int NS = SIDE * SIDE;
  localparam int CAW = $clog2(NS);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_POS = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_MEAS = 3'd5;
  localparam logic [2:0] S_OUT = 3'd6;
  localparam logic [2:0] S_POS0 = 3'd7;

  logic [2:0]  state;
  logic [4:0]  step;
  logic [CAW:0] ccnt;
  logic        placed [MAX_PARTICLES];
  logic        pl_q, p0_q;
  logic        idx_ok, cur_placed, meas, p0_placed;
  logic [9:0]  pidx;
  logic [1:0]  status;
  logic [2:0]  cls_q;
  logic        cv;

  localparam int PW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

  assign clr_run = (state == S_CLEAR);
  assign clr_addr = ccnt[CAW-1:0];
  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.status = status;
  assign out_ch.neighbour_class = cls_q;
  assign out_ch.class_valid = cv;
  assign out_ch.new_row = (idx_ok && cur_placed) ? pos_row : 6'd0;
  assign out_ch.new_col = (idx_ok && cur_placed) ? pos_col : 6'd0;

  // sequence tables: place checks 0..4, place writes 0..4;
  // move: self check 0, excl checks 1..5, writes 0..7, commit 8; meas 0..4 then drain to 7
  function automatic hclme_cmd_t seq(input logic [2:0] st, input logic [4:0] s,
                                     input logic op);
    hclme_cmd_t c;
    c = '0;
    if (st == S_CHECK && op == OP_PLACE) begin
      c.rd = 1'b1;
      c.chk_empty = 1'b1;
      case (s)
        5'd0: begin c.dr = 4'd0; c.dc = 4'd0; end
        5'd1: begin c.dr = 4'd1; c.dc = 4'd0; end
        5'd2: begin c.dr = 4'hF; c.dc = 4'd0; end
        5'd3: begin c.dr = 4'd0; c.dc = 4'd1; end
        5'd4: begin c.dr = 4'd0; c.dc = 4'hF; end
        default: begin c.rd = 1'b0; c.chk_empty = 1'b0; end
      endcase
    end else if (st == S_WRITE && op == OP_PLACE) begin
      c.wr = 1'b1;
      c.wdata = SITE_ARM;
      case (s)
        5'd0: begin c.dr = 4'd1; c.dc = 4'd0; end
        5'd1: begin c.dr = 4'hF; c.dc = 4'd0; end
        5'd2: begin c.dr = 4'd0; c.dc = 4'd1; end
        5'd3: begin c.dr = 4'd0; c.dc = 4'hF; end
        default: begin c.wdata = SITE_CENTER; c.commit_pos = 1'b1; end
      endcase
    end else if (st == S_CHECK) begin
      // move, offsets as (forward, side)
      c.rd = 1'b1;
      case (s)
        5'd0: begin c.chk_self = 1'b1; end
        5'd1: begin c.chk_center = 1'b1; c.dr = 4'd3; c.dc = 4'd0; end
        5'd2: begin c.chk_center = 1'b1; c.dr = 4'd2; c.dc = 4'd1; end
        5'd3: begin c.chk_center = 1'b1; c.dr = 4'd2; c.dc = 4'hF; end
        5'd4: begin c.chk_center = 1'b1; c.dr = 4'd1; c.dc = 4'd2; end
        5'd5: begin c.chk_center = 1'b1; c.dr = 4'd1; c.dc = 4'hE; end
        default: c.rd = 1'b0;
      endcase
    end else if (st == S_WRITE) begin
      c.wr = 1'b1;
      case (s)
        5'd0: begin c.wdata = SITE_CENTER; c.dr = 4'd1; end
        5'd1: begin c.wdata = SITE_ARM; c.dr = 4'd2; end
        5'd2: begin c.wdata = SITE_ARM; c.dr = 4'd0; end
        5'd3: begin c.wdata = SITE_ARM; c.dr = 4'd1; c.dc = 4'd1; end
        5'd4: begin c.wdata = SITE_ARM; c.dr = 4'd1; c.dc = 4'hF; end
        5'd5: begin c.wdata = SITE_EMPTY; c.dc = 4'd1; end
        5'd6: begin c.wdata = SITE_EMPTY; c.dc = 4'hF; end
        5'd7: begin c.wdata = SITE_EMPTY; c.dr = 4'hF; end
        default: begin c.wr = 1'b0; c.dr = 4'd1; c.commit_pos = 1'b1; end
      endcase
    end else if (st == S_MEAS) begin
      c.use_p0 = 1'b1;
      c.rd = 1'b1;
      case (s)
        5'd0: begin c.dr = 4'hE; c.dc = 4'd1; c.cls_bit = 3'd1; end
        5'd1: begin c.dr = 4'hF; c.dc = 4'd2; c.cls_bit = 3'd2; end
        5'd2: begin c.dr = 4'd0; c.dc = 4'd3; c.cls_bit = 3'd3; end
        5'd3: begin c.dr = 4'd1; c.dc = 4'd2; c.cls_bit = 3'd4; end
        5'd4: begin c.dr = 4'd2; c.dc = 4'd1; c.cls_bit = 3'd5; end
        default: c.rd = 1'b0;
      endcase
    end
    return c;
  endfunction

  always_comb begin
    cmd = seq(state, step, opcode);
    cmd.load = in_ch.valid && in_ch.ready;
    cmd.clr_acc = (state == S_IDLE);
    // stored position needed for a move, or for a place on a used index
    cmd.pos_rd = (state == S_POS) && (opcode == OP_MOVE || pl_q);
  end

  always_ff @(posedge clk) begin
    if (state == S_WRITE && opcode == OP_PLACE && step == 5'd4) begin
      placed[PW'(pidx)] <= 1'b1;
    end
    if (state == S_CLEAR) begin
      placed[ccnt[PW-1:0]] <= 1'b0;
    end
    if (in_ch.valid && in_ch.ready) begin
      pl_q <= placed[PW'(in_ch.particle)];
      p0_q <= placed[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ccnt <= '0;
      step <= '0;
      opcode <= OP_PLACE;
      idx_ok <= 1'b0;
      cur_placed <= 1'b0;
      p0_placed <= 1'b0;
      meas <= 1'b0;
      pidx <= '0;
      status <= ST_DONE;
      cls_q <= '0;
      cv <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          ccnt <= ccnt + 1'b1;
          if (ccnt == (CAW+1)'(NS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            opcode <= in_ch.opcode;
            pidx <= in_ch.particle;
            meas <= in_ch.measure;
            idx_ok <= ({22'd0, in_ch.particle} < 32'(MAX_PARTICLES));
            step <= '0;
            cls_q <= '0;
            cv <= 1'b0;
            state <= S_POS;
          end
        end
        S_POS: begin
          cur_placed <= idx_ok && pl_q;
          p0_placed <= p0_q;
          state <= S_CHECK;
          if (!idx_ok || (pl_q == (opcode == OP_PLACE))) begin
            status <= ST_BAD;
            state <= S_MEAS;
          end
        end
        S_CHECK: begin
          step <= step + 1'b1;
          if (step == 5'd7) begin
            step <= '0;
            if (sts.self_bad) begin
              status <= ST_BAD;
              state <= S_MEAS;
            end else if (sts.hit) begin
              status <= ST_BLOCKED;
              state <= S_MEAS;
            end else begin
              status <= ST_DONE;
              state <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          step <= step + 1'b1;
          if ((opcode == OP_PLACE && step == 5'd4) || step == 5'd8) begin
            step <= '0;
            if (opcode == OP_PLACE) cur_placed <= 1'b1;
            if (opcode == OP_PLACE && pidx == 10'd0) p0_placed <= 1'b1;
            state <= S_POS0;
          end
        end
        S_POS0: begin
          state <= S_MEAS;
        end
        S_MEAS: begin
          step <= step + 1'b1;
          if (!meas || !p0_placed) begin
            state <= S_OUT;
          end else if (step == 5'd7) begin
            cls_q <= cls;
            cv <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ch.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### src/hard_cross_lattice_move_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hard_cross_lattice_move_engine: hard-cross lattice place/move engine
// Controller and datapath around a single-port site memory.
// ----------------------------------------------------------------------------
// After reset the block clears the site memory, one site a cycle, all SIDE*SIDE
// sites (4096 at the default), and accepts no item meanwhile. Each item then
// passes in order through acceptance, a position lookup, the site checks
// (place 5 reads, move 6 reads, plus read latency), on success the site writes
// (place 5 writes, move 8 writes and a position commit) and a settle step, the
// neighbour measurement when requested, and the result beat. A blocked item
// skips the writes; a rejected item skips the checks as well. All site accesses
// go one after another through the single site-memory port. One item is in
// flight at a time.
module hard_cross_lattice_move_engine #(
  parameter int SIDE = hclme_pkg::SIDE_DEF,
  parameter int MAX_PARTICLES = hclme_pkg::MAX_PART_DEF
) (
  input logic         clk,
  input logic         rst,
  hclme_in_if.sink    in_ch,
  hclme_out_if.source out_ch
);
  import hclme_pkg::*;

  hclme_cmd_t cmd;
  hclme_sts_t sts;
  logic [5:0] pos_row, pos_col;
  logic [2:0] cls;
  logic       clr_run, opcode;
  logic [$clog2(SIDE*SIDE)-1:0] clr_addr;

  hclme_ctrl #(.SIDE(SIDE), .MAX_PARTICLES(MAX_PARTICLES)) u_ctrl (
    .clk, .rst, .in_ch, .out_ch, .sts, .pos_row, .pos_col, .cls, .cmd,
    .clr_run, .clr_addr, .opcode
  );

  hclme_datapath #(.SIDE(SIDE), .MAX_PARTICLES(MAX_PARTICLES)) u_dp (
    .clk, .rst, .cmd,
    .particle(in_ch.particle), .direction(in_ch.direction),
    .place_row(in_ch.place_row), .place_col(in_ch.place_col),
    .opcode, .clr_run, .clr_addr, .sts, .pos_row, .pos_col, .cls
  );

`ifndef SYNTHESIS
  a_no_accept_when_out: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready) else $error("input taken while result pending");
  a_out_after_ready: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready) |=> !out_ch.valid) else $error("result repeated");
  a_cls_gate: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.class_valid) |-> out_ch.neighbour_class == 3'd0)
    else $error("class without valid");
`endif

endmodule
